[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BSR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bsr checker: same-cycle rule broken");

// Next-cycle implication, disabled while reset is low.
`define BSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bsr checker: next-cycle rule broken");

`endif

[sv/bsr_pkg.sv]
// Package: command codes, register addresses, status and command structs, map codes.
`default_nettype none
package bsr_pkg;

	localparam int SIZE_W = 17;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam logic [1:0] MAP_BG   = 2'd0;
	localparam logic [1:0] MAP_SET  = 2'd1;
	localparam logic [1:0] MAP_SEEN = 2'd2;

	localparam logic [4:0] OP_IDLE      = 5'd0;
	localparam logic [4:0] OP_CLEAR     = 5'd1;
	localparam logic [4:0] OP_LOAD      = 5'd2;
	localparam logic [4:0] OP_LOAD_LAST = 5'd3;
	localparam logic [4:0] OP_SCAN_RD   = 5'd4;
	localparam logic [4:0] OP_SEED      = 5'd5;
	localparam logic [4:0] OP_SCAN_NEXT = 5'd6;
	localparam logic [4:0] OP_POP       = 5'd7;
	localparam logic [4:0] OP_POPW      = 5'd8;
	localparam logic [4:0] OP_NB_RD     = 5'd9;
	localparam logic [4:0] OP_NB_PUSH   = 5'd10;
	localparam logic [4:0] OP_NB_NEXT   = 5'd11;
	localparam logic [4:0] OP_RANK      = 5'd12;
	localparam logic [4:0] OP_RK_RDLAST = 5'd13;
	localparam logic [4:0] OP_RK_RD     = 5'd14;
	localparam logic [4:0] OP_RK_SHIFT  = 5'd15;
	localparam logic [4:0] OP_RK_PUT    = 5'd16;
	localparam logic [4:0] OP_EM_RD     = 5'd17;
	localparam logic [4:0] OP_EM_LOAD   = 5'd18;
	localparam logic [4:0] OP_EM_NONE   = 5'd19;
	localparam logic [4:0] OP_FINISH    = 5'd20;

	typedef struct packed {
		logic [4:0] op;
	} bsr_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic map_set;
		logic scan_last;
		logic stack_empty;
		logic nb_ok;
		logic nb_last;
		logic rank_full;
		logic ri_zero;
		logic rk_less;
		logic rk_le_last;
		logic kept_zero;
		logic out_last;
	} bsr_sts_t;

endpackage
`default_nettype wire

[sv/bsr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

[sv/bsr_ctrl.sv]
// Controller: sequences load, scan, flood fill, ranking, emission and clear.
`default_nettype none
module bsr_ctrl import bsr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     pix_valid,
	output logic          pix_ready,
	input  wire logic     last_pixel,
	output logic          res_valid,
	input  wire logic     res_ready,
	input  wire bsr_sts_t sts,
	output bsr_cmd_t      cmd
);
	localparam logic [4:0] S_CLEAR   = 5'd0;
	localparam logic [4:0] S_LOAD    = 5'd1;
	localparam logic [4:0] S_SCAN    = 5'd2;
	localparam logic [4:0] S_SCANW   = 5'd3;
	localparam logic [4:0] S_ADV     = 5'd4;
	localparam logic [4:0] S_POP     = 5'd5;
	localparam logic [4:0] S_POPW    = 5'd6;
	localparam logic [4:0] S_NB      = 5'd7;
	localparam logic [4:0] S_NBW     = 5'd8;
	localparam logic [4:0] S_RANK    = 5'd9;
	localparam logic [4:0] S_RKLAST  = 5'd10;
	localparam logic [4:0] S_RKLASTW = 5'd11;
	localparam logic [4:0] S_RKSTEP  = 5'd12;
	localparam logic [4:0] S_RKW     = 5'd13;
	localparam logic [4:0] S_EMIT    = 5'd14;
	localparam logic [4:0] S_EMW     = 5'd15;
	localparam logic [4:0] S_OUT     = 5'd16;

	logic [4:0] state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd.op    = OP_IDLE;
		pix_ready = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (sts.clr_done) state_nxt = S_LOAD;
			end
			S_LOAD: begin
				pix_ready = 1'b1;
				if (pix_valid) begin
					if (last_pixel) begin
						cmd.op    = OP_LOAD_LAST;
						state_nxt = S_SCAN;
					end else begin
						cmd.op = OP_LOAD;
					end
				end
			end
			S_SCAN: begin
				cmd.op    = OP_SCAN_RD;
				state_nxt = S_SCANW;
			end
			S_SCANW: begin
				if (sts.map_set) begin
					cmd.op    = OP_SEED;
					state_nxt = S_POP;
				end else begin
					state_nxt = S_ADV;
				end
			end
			S_ADV: begin
				if (sts.scan_last) begin
					state_nxt = S_EMIT;
				end else begin
					cmd.op    = OP_SCAN_NEXT;
					state_nxt = S_SCAN;
				end
			end
			S_POP: begin
				if (sts.stack_empty) begin
					state_nxt = S_RANK;
				end else begin
					cmd.op    = OP_POP;
					state_nxt = S_POPW;
				end
			end
			S_POPW: begin
				cmd.op    = OP_POPW;
				state_nxt = S_NB;
			end
			S_NB: begin
				if (sts.nb_ok) begin
					cmd.op    = OP_NB_RD;
					state_nxt = S_NBW;
				end else begin
					cmd.op    = OP_NB_NEXT;
					state_nxt = sts.nb_last ? S_POP : S_NB;
				end
			end
			S_NBW: begin
				cmd.op    = sts.map_set ? OP_NB_PUSH : OP_NB_NEXT;
				state_nxt = sts.nb_last ? S_POP : S_NB;
			end
			S_RANK: begin
				cmd.op    = OP_RANK;
				state_nxt = sts.rank_full ? S_RKLAST : S_RKSTEP;
			end
			S_RKLAST: begin
				cmd.op    = OP_RK_RDLAST;
				state_nxt = S_RKLASTW;
			end
			S_RKLASTW: begin
				state_nxt = sts.rk_le_last ? S_ADV : S_RKSTEP;
			end
			S_RKSTEP: begin
				if (sts.ri_zero) begin
					cmd.op    = OP_RK_PUT;
					state_nxt = S_ADV;
				end else begin
					cmd.op    = OP_RK_RD;
					state_nxt = S_RKW;
				end
			end
			S_RKW: begin
				if (sts.rk_less) begin
					cmd.op    = OP_RK_SHIFT;
					state_nxt = S_RKSTEP;
				end else begin
					cmd.op    = OP_RK_PUT;
					state_nxt = S_ADV;
				end
			end
			S_EMIT: begin
				if (sts.kept_zero) begin
					cmd.op    = OP_EM_NONE;
					state_nxt = S_OUT;
				end else begin
					cmd.op    = OP_EM_RD;
					state_nxt = S_EMW;
				end
			end
			S_EMW: begin
				cmd.op    = OP_EM_LOAD;
				state_nxt = S_OUT;
			end
			S_OUT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					if (sts.out_last) begin
						cmd.op    = OP_FINISH;
						state_nxt = S_CLEAR;
					end else begin
						state_nxt = S_EMIT;
					end
				end
			end
			default: state_nxt = S_CLEAR;
		endcase
	end
endmodule
`default_nettype wire

[sv/bsr_dpath.sv]
// Datapath: config registers, pixel map, fill stack, ranked sizes, result word.
`default_nettype none
module bsr_dpath import bsr_pkg::*; #(
	parameter int MAX_ROWS       = 256,
	parameter int MAX_COLS       = 256,
	parameter int MAX_COMPONENTS = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_addr,
	input  wire logic [8:0]        cfg_wdata,
	input  wire logic              pixel,
	input  wire bsr_cmd_t          cmd,
	output bsr_sts_t               sts,
	output logic      [SIZE_W-1:0] region_size,
	output logic                   last_size,
	output logic                   overflow,
	output logic                   none_found
);
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int NRW   = $clog2(MAX_ROWS + 1);
	localparam int NCW   = $clog2(MAX_COLS + 1);
	localparam int SW    = $clog2(DEPTH + 1);
	localparam int IW    = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
	localparam int KW    = $clog2(MAX_COMPONENTS + 1);

	logic [8:0]     rows_q, cols_q;
	logic [NRW-1:0] nr_cfg, nr_q;
	logic [NCW-1:0] nc_cfg, nc_q;
	logic [AW:0]    area, load_pos_q;
	logic [AW-1:0]  clr_q, scan_p_q, cur_p, q;
	logic [RW-1:0]  sr_q, cur_r, qr, pop_r;
	logic [CW-1:0]  sc_q, cur_c, qc, pop_c;
	logic [AW:0]    sp_q;
	logic [1:0]     k_q;
	logic           nb_ok;
	logic [SW-1:0]  size_q, res_size_q;
	logic [KW-1:0]  kept_q;
	logic [IW-1:0]  ri_q, ei_q;
	logic           ovf_q, res_last_q, res_ovf_q, res_none_q;
	logic [RW+NCW-1:0] pop_prod;
	logic [31:0]    size_ext;

	// map port
	logic          map_we;
	logic [AW-1:0] map_waddr, map_raddr;
	logic [1:0]    map_wdata, map_rdata;
	// stack port
	logic             st_we;
	logic [RW+CW-1:0] st_wdata, st_rdata;
	// rank port
	logic          rk_we;
	logic [IW-1:0] rk_waddr, rk_raddr;
	logic [SW-1:0] rk_wdata, rk_rdata;

	// clamp: zero acts as one, above max saturates
	always_comb begin
		if (rows_q == 9'd0) nr_cfg = NRW'(1);
		else if (11'(rows_q) > 11'(MAX_ROWS)) nr_cfg = NRW'(MAX_ROWS);
		else nr_cfg = NRW'(rows_q);
		if (cols_q == 9'd0) nc_cfg = NCW'(1);
		else if (11'(cols_q) > 11'(MAX_COLS)) nc_cfg = NCW'(MAX_COLS);
		else nc_cfg = NCW'(cols_q);
	end

	assign area = (AW+1)'(nr_cfg * nc_cfg);

	// neighbour k of the current pixel: up, left, down, right
	always_comb begin
		q  = cur_p;
		qr = cur_r;
		qc = cur_c;
		case (k_q)
			2'd0: begin
				nb_ok = (cur_r != '0);
				q     = cur_p - AW'(nc_q);
				qr    = cur_r - RW'(1);
			end
			2'd1: begin
				nb_ok = (cur_c != '0);
				q     = cur_p - AW'(1);
				qc    = cur_c - CW'(1);
			end
			2'd2: begin
				nb_ok = (NRW'(cur_r) + NRW'(1)) < nr_q;
				q     = cur_p + AW'(nc_q);
				qr    = cur_r + RW'(1);
			end
			default: begin
				nb_ok = (NCW'(cur_c) + NCW'(1)) < nc_q;
				q     = cur_p + AW'(1);
				qc    = cur_c + CW'(1);
			end
		endcase
	end

	assign pop_r    = st_rdata[RW+CW-1:CW];
	assign pop_c    = st_rdata[CW-1:0];
	assign pop_prod = pop_r * nc_q;

	// memory port steering
	always_comb begin
		map_we    = 1'b0;
		map_waddr = scan_p_q;
		map_wdata = MAP_SEEN;
		map_raddr = (cmd.op == OP_NB_RD) ? q : scan_p_q;
		st_we     = 1'b0;
		st_wdata  = {sr_q, sc_q};
		rk_we     = 1'b0;
		rk_waddr  = ri_q;
		rk_wdata  = size_q;
		rk_raddr  = ei_q;
		case (cmd.op)
			OP_CLEAR: begin
				map_we    = 1'b1;
				map_waddr = clr_q;
				map_wdata = MAP_BG;
			end
			OP_LOAD, OP_LOAD_LAST: begin
				map_we    = (load_pos_q < area);
				map_waddr = load_pos_q[AW-1:0];
				map_wdata = {1'b0, pixel};
			end
			OP_SEED: begin
				map_we = 1'b1;
				st_we  = 1'b1;
			end
			OP_NB_PUSH: begin
				map_we    = 1'b1;
				map_waddr = q;
				st_we     = 1'b1;
				st_wdata  = {qr, qc};
			end
			OP_RK_RDLAST: rk_raddr = IW'(MAX_COMPONENTS - 1);
			OP_RK_RD:     rk_raddr = ri_q - IW'(1);
			OP_RK_SHIFT: begin
				rk_we    = 1'b1;
				rk_wdata = rk_rdata;
			end
			OP_RK_PUT: rk_we = 1'b1;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q     <= 9'd256;
			cols_q     <= 9'd256;
			clr_q      <= '0;
			load_pos_q <= '0;
			sp_q       <= '0;
			k_q        <= '0;
			kept_q     <= '0;
			ri_q       <= '0;
			ei_q       <= '0;
			ovf_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == REG_ROWS) rows_q <= cfg_wdata;
				else cols_q <= cfg_wdata;
			end
			case (cmd.op)
				OP_CLEAR:  clr_q <= clr_q + AW'(1);
				OP_FINISH: begin
					clr_q      <= '0;
					load_pos_q <= '0;
				end
				OP_LOAD: if (load_pos_q < area) load_pos_q <= load_pos_q + (AW+1)'(1);
				OP_LOAD_LAST: begin
					sp_q   <= '0;
					kept_q <= '0;
					ei_q   <= '0;
					ovf_q  <= 1'b0;
				end
				OP_SEED, OP_NB_PUSH: begin
					sp_q <= sp_q + (AW+1)'(1);
					if (cmd.op == OP_NB_PUSH) k_q <= k_q + 2'd1;
				end
				OP_POP:     sp_q <= sp_q - (AW+1)'(1);
				OP_POPW:    k_q  <= '0;
				OP_NB_NEXT: k_q  <= k_q + 2'd1;
				OP_RANK: begin
					if (kept_q == KW'(MAX_COMPONENTS)) begin
						ri_q  <= IW'(MAX_COMPONENTS - 1);
						ovf_q <= 1'b1;
					end else begin
						ri_q   <= kept_q[IW-1:0];
						kept_q <= kept_q + KW'(1);
					end
				end
				OP_RK_SHIFT: ri_q <= ri_q - IW'(1);
				OP_EM_LOAD:  ei_q <= ei_q + IW'(1);
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD_LAST: begin
				nr_q     <= nr_cfg;
				nc_q     <= nc_cfg;
				sr_q     <= '0;
				sc_q     <= '0;
				scan_p_q <= '0;
			end
			OP_SCAN_NEXT: begin
				scan_p_q <= scan_p_q + AW'(1);
				if ((NCW'(sc_q) + NCW'(1)) == nc_q) begin
					sc_q <= '0;
					sr_q <= sr_q + RW'(1);
				end else begin
					sc_q <= sc_q + CW'(1);
				end
			end
			OP_SEED: size_q <= '0;
			OP_POPW: begin
				cur_r  <= pop_r;
				cur_c  <= pop_c;
				cur_p  <= AW'(pop_prod) + AW'(pop_c);
				size_q <= size_q + SW'(1);
			end
			OP_EM_LOAD: begin
				res_size_q <= rk_rdata;
				res_last_q <= (KW'(ei_q) + KW'(1)) == kept_q;
				res_ovf_q  <= ovf_q;
				res_none_q <= 1'b0;
			end
			OP_EM_NONE: begin
				res_size_q <= '0;
				res_last_q <= 1'b1;
				res_ovf_q  <= 1'b0;
				res_none_q <= 1'b1;
			end
			default: ;
		endcase
	end

	bsr_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_map (
		.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.raddr(map_raddr), .rdata(map_rdata)
	);

	bsr_ram #(.WIDTH(RW + CW), .DEPTH(DEPTH)) u_stack (
		.clk(clk), .we(st_we), .waddr(sp_q[AW-1:0]), .wdata(st_wdata),
		.raddr(AW'(sp_q - (AW+1)'(1))), .rdata(st_rdata)
	);

	bsr_ram #(.WIDTH(SW), .DEPTH(MAX_COMPONENTS)) u_rank (
		.clk(clk), .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata),
		.raddr(rk_raddr), .rdata(rk_rdata)
	);

	always_comb begin
		sts.clr_done    = (clr_q == AW'(DEPTH - 1));
		sts.map_set     = (map_rdata == MAP_SET);
		sts.scan_last   = ((NRW'(sr_q) + NRW'(1)) == nr_q) &&
			((NCW'(sc_q) + NCW'(1)) == nc_q);
		sts.stack_empty = (sp_q == '0);
		sts.nb_ok       = nb_ok;
		sts.nb_last     = (k_q == 2'd3);
		sts.rank_full   = (kept_q == KW'(MAX_COMPONENTS));
		sts.ri_zero     = (ri_q == '0);
		sts.rk_less     = (rk_rdata < size_q);
		sts.rk_le_last  = (size_q <= rk_rdata);
		sts.kept_zero   = (kept_q == '0);
		sts.out_last    = res_last_q;
	end

	assign size_ext    = 32'(res_size_q);
	assign region_size = size_ext[SIZE_W-1:0];
	assign last_size   = res_last_q;
	assign overflow    = res_ovf_q;
	assign none_found  = res_none_q;
endmodule
`default_nettype wire

[sv/blob_size_ranker.sv]
// Top level: 4-connected blob labelling with ranked region sizes.
//
//  channel  | handshake            | word
//  ---------+----------------------+-------------------------------------------
//  pixels   | pix_valid/pix_ready  | pixel, last_pixel
//  results  | res_valid/res_ready  | region_size, last_size, overflow, none_found
//  config   | cfg_we (no wait)     | cfg_addr, cfg_wdata
//
// After reset and after the last result word of each image, a clearing pass
// writes the whole pixel map with pix_ready low. Loading takes one pixel
// word per cycle. Labelling then runs on the single map port: each scanned
// position is read, awaited and advanced; each popped pixel is popped and
// awaited, each in-image neighbour is read and awaited, and a neighbour
// outside the image is stepped past; each region then has an empty-stack
// check and a sorted insert into the ranked list. Each result word is read
// and loaded (the no-region word directly), and may stall on res_ready.
// One image is in flight at a time; pixels wait while results are pending.
`default_nettype none
module blob_size_ranker import bsr_pkg::*; #(
	parameter int MAX_ROWS       = 256,
	parameter int MAX_COLS       = 256,
	parameter int MAX_COMPONENTS = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_addr,
	input  wire logic [8:0]        cfg_wdata,
	input  wire logic              pix_valid,
	output logic                   pix_ready,
	input  wire logic              pixel,
	input  wire logic              last_pixel,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output logic      [SIZE_W-1:0] region_size,
	output logic                   last_size,
	output logic                   overflow,
	output logic                   none_found
);
	bsr_cmd_t cmd;
	bsr_sts_t sts;

	// sequencer
	bsr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_ready(pix_ready), .last_pixel(last_pixel),
		.res_valid(res_valid), .res_ready(res_ready),
		.sts(sts), .cmd(cmd)
	);

	// map, stack, ranked list and result register
	bsr_dpath #(
		.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_COMPONENTS(MAX_COMPONENTS)
	) u_dpath (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.pixel(pixel), .cmd(cmd), .sts(sts),
		.region_size(region_size), .last_size(last_size),
		.overflow(overflow), .none_found(none_found)
	);
endmodule
`default_nettype wire

[sv/bsr_checker.sv]
// Port-level checker for the blob ranker, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module bsr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        pix_ready,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [16:0] region_size,
	input wire logic        last_size,
	input wire logic        overflow,
	input wire logic        none_found
);
	// stalled result word holds
	`BSR_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(region_size) && $stable(last_size))
	// an empty image gives a single zero-size word
	`BSR_ASSERT_NOW(a_none_word, clk, arst_n, res_valid && none_found, last_size && (region_size == 17'd0) && !overflow)
	// no pixel taken while a result is pending
	`BSR_ASSERT_NOW(a_no_overlap, clk, arst_n, res_valid, !pix_ready)
	// more words follow a non-final one before any pixel
	`BSR_ASSERT_NEXT(a_run_on, clk, arst_n, res_valid && res_ready && !last_size, !pix_ready)
endmodule

bind blob_size_ranker bsr_checker u_bsr_checker (.*);
`default_nettype wire

[tb/sv/tb_top.sv]
// Testbench for blob_size_ranker: streamed images against a flood-fill predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import bsr_pkg::*;

	localparam int MAP_CELLS  = 256 * 256;
	localparam int KEEP_MAX   = 64;
	localparam int IDLE_LIMIT = 1000000;  // clear pass + full 256x256 labelling + stalls
	localparam int HOLD_LEN   = 400;

	typedef struct {
		logic [SIZE_W-1:0] sz;
		logic              last;
		logic              ovf;
		logic              none;
	} size_word_t;

	// one row of the directed table: a geometry write or one pixel word
	typedef struct {
		bit         is_cfg;
		logic [8:0] r, c;
		bit         p, l;
		bit         typed;    // expected words given below rather than predicted
		size_word_t w;
	} stim_row_t;

	logic clk, arst_n;
	logic cfg_we, cfg_addr;
	logic [8:0] cfg_wdata;
	logic pix_valid, pix_ready, pixel, last_pixel;
	logic res_valid, res_ready;
	logic [SIZE_W-1:0] region_size;
	logic last_size, overflow, none_found;

	blob_size_ranker u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.pix_valid(pix_valid), .pix_ready(pix_ready),
		.pixel(pixel), .last_pixel(last_pixel),
		.res_valid(res_valid), .res_ready(res_ready),
		.region_size(region_size), .last_size(last_size),
		.overflow(overflow), .none_found(none_found)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---- predictor state: own copy of the map and geometry registers ----
	byte        img_map [MAP_CELLS];   // 0 background, 1 set, 2 visited
	int         load_pos;
	logic [8:0] rows_reg, cols_reg;
	size_word_t sizes_due [$];         // words still owed by the block
	size_word_t fresh [$];             // words of the latest prediction

	int  errors;
	int  items_sent;
	int  words_seen;
	bit  burst;                        // no sender gaps while set
	bit  hold_req;                     // receiver long hold-off request

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		errors++;
	endtask

	// Effect of one accepted pixel word; words it causes land in fresh.
	function automatic void label_pixel(bit p, bit l);
		int nr, nc, area, q, r, c, sz;
		int stk [$];
		int found [$];
		bit ovf;
		fresh.delete();
		nr = (rows_reg == 0) ? 1 : (rows_reg > 256 ? 256 : rows_reg);
		nc = (cols_reg == 0) ? 1 : (cols_reg > 256 ? 256 : cols_reg);
		area = nr * nc;
		if (load_pos < area) begin
			img_map[load_pos] = byte'(p);
			load_pos++;
		end
		if (!l)
			return;
		for (int s = 0; s < area; s++) begin
			if (img_map[s] == 1) begin
				img_map[s] = 2;
				stk.push_back(s);
				sz = 0;
				while (stk.size() > 0) begin
					q = stk.pop_back();
					sz++;
					r = q / nc;
					c = q % nc;
					if (r > 0 && img_map[q-nc] == 1) begin
						img_map[q-nc] = 2; stk.push_back(q - nc);
					end
					if (c > 0 && img_map[q-1] == 1) begin
						img_map[q-1] = 2; stk.push_back(q - 1);
					end
					if (r + 1 < nr && img_map[q+nc] == 1) begin
						img_map[q+nc] = 2; stk.push_back(q + nc);
					end
					if (c + 1 < nc && img_map[q+1] == 1) begin
						img_map[q+1] = 2; stk.push_back(q + 1);
					end
				end
				found.push_back(sz);
			end
		end
		foreach (img_map[i])
			img_map[i] = 0;
		load_pos = 0;
		if (found.size() == 0) begin
			fresh.push_back('{sz: '0, last: 1'b1, ovf: 1'b0, none: 1'b1});
			return;
		end
		found.rsort();
		ovf = found.size() > KEEP_MAX;
		while (found.size() > KEEP_MAX)
			void'(found.pop_back());
		foreach (found[i])
			fresh.push_back('{sz: SIZE_W'(found[i]), last: (i == found.size() - 1),
				ovf: ovf, none: 1'b0});
	endfunction

	// mostly short gaps, a few long ones, none during a burst
	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (burst || k < 50) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Present one pixel word and hold it until accepted.
	task automatic put_pixel(input bit p, input bit l);
		int g;
		g = pick_gap();
		if (g > 0) begin
			pix_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		pix_valid  <= 1'b1;
		pixel      <= p;
		last_pixel <= l;
		do @(posedge clk); while (!pix_ready);
		items_sent++;
	endtask

	// Predict and send; the word's results join the queue of sizes due.
	task automatic send_pixel(input bit p, input bit l);
		label_pixel(p, l);
		foreach (fresh[i])
			sizes_due.push_back(fresh[i]);
		put_pixel(p, l);
	endtask

	// Wait until the block owes nothing and has finished its clearing pass.
	task automatic drain();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (sizes_due.size() > 0)
			@(posedge clk);
		do @(posedge clk); while (!pix_ready);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_geometry(input logic [8:0] r, input logic [8:0] c);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_ROWS;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_addr  <= REG_COLS;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we    <= 1'b0;
		rows_reg = r;
		cols_reg = c;
	endtask

	// ---- receiver: random ready, with a long hold-off on request ----
	initial begin
		res_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && res_valid) begin
				res_ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				hold_req = 1'b0;
			end else if (burst) begin
				res_ready <= 1'b1;
			end else begin
				res_ready <= ($urandom_range(0, 9) < 7);
			end
		end
	end

	// ---- result checker ----
	always @(posedge clk) begin
		size_word_t e;
		if (arst_n && res_valid && res_ready) begin
			words_seen++;
			if (sizes_due.size() == 0) begin
				report($sformatf("unexpected word size=%0d", region_size));
			end else begin
				e = sizes_due.pop_front();
				if (region_size !== e.sz)
					report($sformatf("region_size %0d, want %0d", region_size, e.sz));
				if (last_size !== e.last)
					report($sformatf("last_size %b, want %b", last_size, e.last));
				if (overflow !== e.ovf)
					report($sformatf("overflow %b, want %b", overflow, e.ovf));
				if (none_found !== e.none)
					report($sformatf("none_found %b, want %b", none_found, e.none));
			end
		end
	end

	// ---- watchdog: cycles with no word moving on either channel ----
	int idle_cycles;
	always @(posedge clk) begin
		if ((pix_valid && pix_ready) || (res_valid && res_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// ---- stimulus ----
	stim_row_t dir_tab [$];

	task automatic add_cfg(input logic [8:0] r, input logic [8:0] c);
		dir_tab.push_back('{is_cfg: 1'b1, r: r, c: c, p: 1'b0, l: 1'b0, typed: 1'b0,
			w: '{sz: '0, last: 1'b0, ovf: 1'b0, none: 1'b0}});
	endtask

	task automatic add_pix(input bit p, input bit l, input bit typed = 1'b0,
			input size_word_t w = '{sz: '0, last: 1'b0, ovf: 1'b0, none: 1'b0});
		dir_tab.push_back('{is_cfg: 1'b0, r: '0, c: '0, p: p, l: l, typed: typed, w: w});
	endtask

	initial begin
		int nr, nc, len, dens, n_img;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_addr   = REG_ROWS;
		cfg_wdata  = '0;
		pix_valid  = 1'b0;
		pixel      = 1'b0;
		last_pixel = 1'b0;
		errors = 0; items_sent = 0; words_seen = 0;
		burst = 1'b0; hold_req = 1'b0; idle_cycles = 0;
		rows_reg = 9'd256;
		cols_reg = 9'd256;
		load_pos = 0;
		foreach (img_map[i])
			img_map[i] = 0;

		// single set pixel, then last at reset geometry: one region of one
		add_pix(1'b1, 1'b1, 1'b1, '{sz: 17'd1, last: 1'b1, ovf: 1'b0, none: 1'b0});
		// zero registers act as 1x1; empty image reports none found
		add_cfg(9'd0, 9'd0);
		add_pix(1'b0, 1'b1, 1'b1, '{sz: 17'd0, last: 1'b1, ovf: 1'b0, none: 1'b1});
		add_pix(1'b1, 1'b1, 1'b1, '{sz: 17'd1, last: 1'b1, ovf: 1'b0, none: 1'b0});
		// rows saturate to 256, one column
		add_cfg(9'd511, 9'd1);
		add_pix(1'b1, 1'b0); add_pix(1'b1, 1'b0); add_pix(1'b0, 1'b0); add_pix(1'b1, 1'b1);
		// cols saturate to 256, one row
		add_cfg(9'd1, 9'd511);
		add_pix(1'b1, 1'b0); add_pix(1'b0, 1'b0); add_pix(1'b1, 1'b1);
		// 2x2 with words beyond the image
		add_cfg(9'd2, 9'd2);
		add_pix(1'b1, 1'b0); add_pix(1'b0, 1'b0); add_pix(1'b0, 1'b0); add_pix(1'b1, 1'b0);
		add_pix(1'b1, 1'b0); add_pix(1'b1, 1'b1);
		// geometry change part way through an image
		add_cfg(9'd2, 9'd3);
		add_pix(1'b1, 1'b0); add_pix(1'b1, 1'b0); add_pix(1'b1, 1'b0);
		add_cfg(9'd3, 9'd2);
		add_pix(1'b0, 1'b0); add_pix(1'b1, 1'b0); add_pix(1'b1, 1'b1);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				drain();
				write_geometry(dir_tab[i].r, dir_tab[i].c);
			end else if (dir_tab[i].typed) begin
				label_pixel(dir_tab[i].p, dir_tab[i].l);
				sizes_due.push_back(dir_tab[i].w);
				put_pixel(dir_tab[i].p, dir_tab[i].l);
			end else begin
				send_pixel(dir_tab[i].p, dir_tab[i].l);
			end
		end

		// random images
		n_img = 0;
		while (items_sent < 310) begin
			if (n_img == 0 || (n_img != 2 && $urandom_range(0, 9) < 7)) begin
				// pause until every owed word is back, then new geometry
				drain();
				if (n_img == 0)
					write_geometry(9'd12, 9'd11);
				else if ($urandom_range(0, 14) == 0)
					write_geometry(9'($urandom_range(1, 40)), 9'($urandom_range(1, 40)));
				else
					write_geometry(9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)));
			end
			burst = ($urandom_range(0, 3) == 0);
			nr = (rows_reg == 0) ? 1 : (rows_reg > 256 ? 256 : rows_reg);
			nc = (cols_reg == 0) ? 1 : (cols_reg > 256 ? 256 : cols_reg);
			len = nr * nc;
			if (n_img != 0) begin
				case ($urandom_range(0, 9))
					0: len = $urandom_range(1, len);           // early last pixel
					1: len = len + $urandom_range(1, 3);       // spill past the image
					default: ;
				endcase
				// keep the image behind the hold-off short enough to leave room after it
				if (n_img == 1 && len > 60)
					len = 60;
				if (len > 320 - items_sent)
					len = 320 - items_sent;
			end
			dens = $urandom_range(15, 85);
			for (int k = 0; k < len; k++) begin
				if (n_img == 0)
					// checkerboard: more isolated regions than are kept
					send_pixel(((k / nc + k % nc) % 2) == 0, k == len - 1);
				else
					send_pixel($urandom_range(0, 99) < dens, k == len - 1);
			end
			// receiver holds off while the next image queues up behind the results
			if (n_img == 1)
				hold_req = 1'b1;
			n_img++;
		end
		burst = 1'b0;

		@(posedge clk);
		pix_valid <= 1'b0;
		while (sizes_due.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
+incdir+sv
sv/bsr_pkg.sv
sv/bsr_ram.sv
sv/bsr_ctrl.sv
sv/bsr_dpath.sv
sv/blob_size_ranker.sv
sv/bsr_checker.sv
tb/sv/tb_top.sv
